FILE: hdl/fbm_perlin_noise_3d_assert.svh
// ----------------------------------------------------------------------------
// fbm_perlin_noise_3d assertion macros
// Implication checks sampled on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FBM_PERLIN_NOISE_3D_ASSERT_SVH
`define FBM_PERLIN_NOISE_3D_ASSERT_SVH

// same-cycle implication
`define FBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fbm_pkg.sv
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared constants, widths and helper functions of the fractal noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbm_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int KW          = $clog2(MAX_OCTAVES + 1);
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ASUM_W      = 17 + KW;
  localparam int DIV_W       = ASUM_W + 2;
  localparam int VSUM_W      = 36 + KW;

  // register indexes on the config port
  localparam logic [2:0] REG_BASE_FREQ = 3'd0;
  localparam logic [2:0] REG_OCT_COUNT = 3'd1;
  localparam logic [2:0] REG_LACUNA    = 3'd2;
  localparam logic [2:0] REG_PERSIST   = 3'd3;
  localparam logic [2:0] REG_SEED      = 3'd4;

  localparam logic [23:0] RST_BASE_FREQ = 24'd5243;
  localparam logic [3:0]  RST_OCT_COUNT = 4'd5;
  localparam logic [15:0] RST_LACUNA    = 16'd8192;
  localparam logic [15:0] RST_PERSIST   = 16'd32768;
  localparam logic [31:0] RST_SEED      = 32'd1337;

  localparam logic [31:0] HASH_CX   = 32'h8da6b343;
  localparam logic [31:0] HASH_CY   = 32'hd8163841;
  localparam logic [31:0] HASH_CZ   = 32'hcb1ab31f;
  localparam logic [31:0] HASH_MIX  = 32'h85ebca6b;
  localparam logic [31:0] SEED_STEP = 32'h9e3779b9;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [23:0] FREQ_MAX = 24'hffffff;

  // gradient dot product picked by the low hash nibble
  function automatic logic signed [19:0] grad(input logic [3:0] h,
                                              input logic signed [17:0] gx,
                                              input logic signed [17:0] gy,
                                              input logic signed [17:0] gz);
    logic signed [19:0] sx, sy, sz, r;
    sx = 20'(gx);
    sy = 20'(gy);
    sz = 20'(gz);
    case (h)
      4'h0, 4'hc: r = sx + sy;
      4'h1, 4'hd: r = -sx + sy;
      4'h2, 4'he: r = sx - sy;
      4'h3, 4'hf: r = -sx - sy;
      4'h4:       r = sx + sz;
      4'h5:       r = -sx + sz;
      4'h6:       r = sx - sz;
      4'h7:       r = -sx - sz;
      4'h8:       r = sy + sz;
      4'h9:       r = -sy + sz;
      4'ha:       r = sy - sz;
      default:    r = -sy - sz;
    endcase
    return r;
  endfunction

  // quintic fade polynomial tail: 6t^2 - 15t + 10, Q.16
  function automatic logic [20:0] ease_poly(input logic [15:0] t2, input logic [15:0] f);
    return 21'(t2) * 21'd6 + 21'd655360 - 21'(f) * 21'd15;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fbm_mul.sv
// ----------------------------------------------------------------------------
// fbm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_mul (
  input  wire logic                               clk_i,
  input  wire logic signed [fbm_pkg::MUL_W-1:0]   a_i,
  input  wire logic signed [fbm_pkg::MUL_W-1:0]   b_i,
  output logic signed      [fbm_pkg::PROD_W-1:0]  p_o
);
  import fbm_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: hdl/fbm_div.sv
// ----------------------------------------------------------------------------
// fbm_div
// Bit-serial restoring divider, truncating, saturated to a signed 16-bit word.
// ----------------------------------------------------------------------------
`default_nettype none

module fbm_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [fbm_pkg::VSUM_W-1:0]  dividend_i,
  input  wire logic        [fbm_pkg::DIV_W-1:0]   divisor_i,
  output logic                                    done_o,
  output logic signed      [15:0]                 quot_o
);
  import fbm_pkg::*;

  localparam int CW = $clog2(VSUM_W);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  dstate_e             state_q;
  logic [CW-1:0]       cnt_q;
  logic [DIV_W:0]      rem_q;
  logic [VSUM_W-1:0]   quo_q;
  logic [DIV_W-1:0]    dvs_q;
  logic                neg_q, zero_q, done_q;
  logic signed [15:0]  res_q;

  logic [DIV_W:0]      shifted;
  logic                fits;

  assign shifted = {rem_q[DIV_W-1:0], quo_q[VSUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dvs_q   <= '0;
      neg_q   <= 1'b0;
      zero_q  <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            neg_q   <= dividend_i[VSUM_W-1];
            quo_q   <= dividend_i[VSUM_W-1] ? VSUM_W'(-dividend_i) : VSUM_W'(dividend_i);
            dvs_q   <= divisor_i;
            zero_q  <= (divisor_i == '0);
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
          quo_q <= {quo_q[VSUM_W-2:0], fits};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(VSUM_W - 1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          if (zero_q) begin
            res_q <= '0;
          end else if (neg_q) begin
            res_q <= (quo_q > VSUM_W'(32768)) ? 16'sh8000 : -$signed(quo_q[15:0]);
          end else begin
            res_q <= (quo_q > VSUM_W'(32767)) ? 16'sh7fff : $signed(quo_q[15:0]);
          end
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

`default_nettype wire

FILE: hdl/fbm_perlin_noise_3d.sv
// ----------------------------------------------------------------------------
// fbm_perlin_noise_3d
// Fractal 3D gradient noise: Q16.16 point in, saturated Q2.14 value out.
// ----------------------------------------------------------------------------
// One point is taken when start is high and busy is low; busy then stays high
// until the result word is shown on noise_value_o for one cycle with done_o
// high, and busy is already low in that cycle. done_o cannot be held off, so
// capture it when it appears. All multiplication runs through one registered
// multiplier, one product per cycle; each octave steps through split, fade,
// six hash products, eight corner mixes, seven blends, frequency, amplitude
// and accumulate. The final normalisation uses a bit-serial divider; registers
// are only to be written while busy is low.
`default_nettype none

`include "fbm_perlin_noise_3d_assert.svh"

module fbm_perlin_noise_3d (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  output logic                    done_o,
  output logic signed [15:0]      noise_value_o
);
  import fbm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_OCT, ST_LOAD, ST_DIV} state_e;

  typedef enum logic [5:0] {
    SP_SX, SP_SY, SP_SZ, SP_T2X, SP_T2Y, SP_T2Z, SP_T3X, SP_T3Y, SP_T3Z,
    SP_EX, SP_EY, SP_EZ, SP_HX0, SP_HX1, SP_HY0, SP_HY1, SP_HZ0, SP_HZ1,
    SP_C0, SP_C1, SP_C2, SP_C3, SP_C4, SP_C5, SP_C6, SP_C7,
    SP_LA0, SP_LA1, SP_LA2, SP_LA3, SP_LB0, SP_LB1, SP_FRQ, SP_LC,
    SP_AMP, SP_ACC, SP_END
  } step_e;

  // config registers
  logic [23:0] base_freq_q;
  logic [3:0]  oct_count_q;
  logic [15:0] lacuna_q;
  logic [15:0] persist_q;
  logic [31:0] seed_cfg_q;

  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_freq_q <= RST_BASE_FREQ;
      oct_count_q <= RST_OCT_COUNT;
      lacuna_q    <= RST_LACUNA;
      persist_q   <= RST_PERSIST;
      seed_cfg_q  <= RST_SEED;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_BASE_FREQ: base_freq_q <= pwdata[23:0];
        REG_OCT_COUNT: oct_count_q <= pwdata[3:0];
        REG_LACUNA:    lacuna_q    <= pwdata[15:0];
        REG_PERSIST:   persist_q   <= pwdata[15:0];
        REG_SEED:      seed_cfg_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BASE_FREQ: prdata = {8'd0, base_freq_q};
      REG_OCT_COUNT: prdata = {28'd0, oct_count_q};
      REG_LACUNA:    prdata = {16'd0, lacuna_q};
      REG_PERSIST:   prdata = {16'd0, persist_q};
      REG_SEED:      prdata = seed_cfg_q;
      default:       prdata = '0;
    endcase
  end

  // sequencer
  state_e              state_q;
  step_e               step_q, last_q;
  logic                lv_q;
  logic [KW-1:0]       k_q;
  logic                done_q;
  logic signed [15:0]  result_q;
  logic [KW-1:0]       cnt;
  logic                accept;
  logic                div_start, div_done;
  logic signed [15:0]  div_quot;

  assign cnt       = (oct_count_q > 4'(MAX_OCTAVES)) ? KW'(MAX_OCTAVES) : KW'(oct_count_q);
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign div_start = (state_q == ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= SP_SX;
      last_q   <= SP_SX;
      lv_q     <= 1'b0;
      k_q      <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      lv_q   <= (state_q == ST_OCT);
      last_q <= step_q;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            k_q     <= '0;
            step_q  <= SP_SX;
            state_q <= (cnt == '0) ? ST_LOAD : ST_OCT;
          end
        end
        ST_OCT: begin
          if (step_q == SP_END) begin
            step_q <= SP_SX;
            k_q    <= k_q + 1'b1;
            if (KW'(k_q + 1'b1) == cnt) begin
              state_q <= ST_LOAD;
            end
          end else begin
            step_q <= step_e'(step_q + 1'b1);
          end
        end
        ST_LOAD: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            result_q <= div_quot;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign noise_value_o = result_q;

  // datapath registers
  logic signed [31:0]       px_q, py_q, pz_q;
  logic [23:0]              freq_q;
  logic [16:0]              amp_q;
  logic [31:0]              seed_q;
  logic signed [VSUM_W-1:0] vsum_q;
  logic [ASUM_W-1:0]        asum_q;
  logic [31:0]              c_q  [3];
  logic [15:0]              f_q  [3];
  logic [15:0]              t2_q [3];
  logic [15:0]              t3_q [3];
  logic [16:0]              e_q  [3];
  logic [31:0]              hv_q [6];
  logic signed [19:0]       n_q  [8];
  logic signed [19:0]       a_q  [4];
  logic signed [19:0]       b_q  [2];
  logic signed [19:0]       nz_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  fbm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // operand select for the step being issued
  logic [2:0]         ci;
  logic [31:0]        hmix0, hmix1;
  logic signed [20:0] diff;

  assign ci    = 3'(step_q - SP_C0);
  assign hmix0 = seed_q ^ (ci[0] ? hv_q[1] : hv_q[0])
                        ^ (ci[1] ? hv_q[3] : hv_q[2])
                        ^ (ci[2] ? hv_q[5] : hv_q[4]);
  assign hmix1 = hmix0 ^ (hmix0 >> 13);

  always_comb begin
    diff  = '0;
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      SP_SX:  begin mul_a = MUL_W'(px_q); mul_b = MUL_W'(freq_q); end
      SP_SY:  begin mul_a = MUL_W'(py_q); mul_b = MUL_W'(freq_q); end
      SP_SZ:  begin mul_a = MUL_W'(pz_q); mul_b = MUL_W'(freq_q); end
      SP_T2X: begin mul_a = MUL_W'(f_q[0]); mul_b = MUL_W'(f_q[0]); end
      SP_T2Y: begin mul_a = MUL_W'(f_q[1]); mul_b = MUL_W'(f_q[1]); end
      SP_T2Z: begin mul_a = MUL_W'(f_q[2]); mul_b = MUL_W'(f_q[2]); end
      SP_T3X: begin mul_a = MUL_W'(t2_q[0]); mul_b = MUL_W'(f_q[0]); end
      SP_T3Y: begin mul_a = MUL_W'(t2_q[1]); mul_b = MUL_W'(f_q[1]); end
      SP_T3Z: begin mul_a = MUL_W'(t2_q[2]); mul_b = MUL_W'(f_q[2]); end
      SP_EX: begin
        mul_a = MUL_W'(t3_q[0]);
        mul_b = MUL_W'(ease_poly(t2_q[0], f_q[0]));
      end
      SP_EY: begin
        mul_a = MUL_W'(t3_q[1]);
        mul_b = MUL_W'(ease_poly(t2_q[1], f_q[1]));
      end
      SP_EZ: begin
        mul_a = MUL_W'(t3_q[2]);
        mul_b = MUL_W'(ease_poly(t2_q[2], f_q[2]));
      end
      SP_HX0: begin mul_a = MUL_W'(c_q[0]); mul_b = MUL_W'(HASH_CX); end
      SP_HX1: begin mul_a = MUL_W'(c_q[0] + 32'd1); mul_b = MUL_W'(HASH_CX); end
      SP_HY0: begin mul_a = MUL_W'(c_q[1]); mul_b = MUL_W'(HASH_CY); end
      SP_HY1: begin mul_a = MUL_W'(c_q[1] + 32'd1); mul_b = MUL_W'(HASH_CY); end
      SP_HZ0: begin mul_a = MUL_W'(c_q[2]); mul_b = MUL_W'(HASH_CZ); end
      SP_HZ1: begin mul_a = MUL_W'(c_q[2] + 32'd1); mul_b = MUL_W'(HASH_CZ); end
      SP_C0, SP_C1, SP_C2, SP_C3, SP_C4, SP_C5, SP_C6, SP_C7: begin
        mul_a = MUL_W'(hmix1);
        mul_b = MUL_W'(HASH_MIX);
      end
      SP_LA0: begin diff = 21'(n_q[1]) - 21'(n_q[0]); mul_b = MUL_W'(e_q[0]); end
      SP_LA1: begin diff = 21'(n_q[3]) - 21'(n_q[2]); mul_b = MUL_W'(e_q[0]); end
      SP_LA2: begin diff = 21'(n_q[5]) - 21'(n_q[4]); mul_b = MUL_W'(e_q[0]); end
      SP_LA3: begin diff = 21'(n_q[7]) - 21'(n_q[6]); mul_b = MUL_W'(e_q[0]); end
      SP_LB0: begin diff = 21'(a_q[1]) - 21'(a_q[0]); mul_b = MUL_W'(e_q[1]); end
      SP_LB1: begin diff = 21'(a_q[3]) - 21'(a_q[2]); mul_b = MUL_W'(e_q[1]); end
      SP_LC:  begin diff = 21'(b_q[1]) - 21'(b_q[0]); mul_b = MUL_W'(e_q[2]); end
      SP_FRQ: begin mul_a = MUL_W'(freq_q); mul_b = MUL_W'(lacuna_q); end
      SP_AMP: begin mul_a = MUL_W'(amp_q); mul_b = MUL_W'(persist_q); end
      SP_ACC: begin mul_a = MUL_W'(amp_q); mul_b = MUL_W'(nz_q); end
      default: ;
    endcase
    if (step_q == SP_LA0 || step_q == SP_LA1 || step_q == SP_LA2 || step_q == SP_LA3 ||
        step_q == SP_LB0 || step_q == SP_LB1 || step_q == SP_LC) begin
      mul_a = MUL_W'(diff);
    end
  end

  // result capture for the step issued last cycle
  logic [2:0]         cl;
  logic signed [17:0] gx, gy, gz;
  logic [3:0]         hnib;
  logic signed [19:0] bbase;
  logic signed [20:0] bsum;
  logic [16:0]        ecap;
  logic [27:0]        nf;

  assign cl   = 3'(last_q - SP_C0);
  assign gx   = $signed({2'b00, f_q[0]}) - (cl[0] ? 18'sd65536 : 18'sd0);
  assign gy   = $signed({2'b00, f_q[1]}) - (cl[1] ? 18'sd65536 : 18'sd0);
  assign gz   = $signed({2'b00, f_q[2]}) - (cl[2] ? 18'sd65536 : 18'sd0);
  assign hnib = prod[3:0] ^ prod[19:16];
  assign ecap = (prod[36:16] > 21'd65536) ? ONE_Q16 : prod[32:16];
  assign nf   = prod[39:12];
  assign bsum = 21'(bbase) + $signed(prod[36:16]);

  always_comb begin
    case (last_q)
      SP_LA0:  bbase = n_q[0];
      SP_LA1:  bbase = n_q[2];
      SP_LA2:  bbase = n_q[4];
      SP_LA3:  bbase = n_q[6];
      SP_LB0:  bbase = a_q[0];
      SP_LB1:  bbase = a_q[2];
      SP_LC:   bbase = b_q[0];
      default: bbase = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      pz_q   <= point_z_i;
      freq_q <= base_freq_q;
      amp_q  <= ONE_Q16;
      seed_q <= seed_cfg_q;
      vsum_q <= '0;
      asum_q <= '0;
    end
    if (state_q == ST_OCT && step_q == SP_ACC) begin
      asum_q <= asum_q + ASUM_W'(amp_q);
    end
    if (state_q == ST_OCT && step_q == SP_END) begin
      seed_q <= seed_q + SEED_STEP;
    end
    if (lv_q) begin
      case (last_q)
        SP_SX:  begin c_q[0] <= prod[63:32]; f_q[0] <= prod[31:16]; end
        SP_SY:  begin c_q[1] <= prod[63:32]; f_q[1] <= prod[31:16]; end
        SP_SZ:  begin c_q[2] <= prod[63:32]; f_q[2] <= prod[31:16]; end
        SP_T2X: t2_q[0] <= prod[31:16];
        SP_T2Y: t2_q[1] <= prod[31:16];
        SP_T2Z: t2_q[2] <= prod[31:16];
        SP_T3X: t3_q[0] <= prod[31:16];
        SP_T3Y: t3_q[1] <= prod[31:16];
        SP_T3Z: t3_q[2] <= prod[31:16];
        SP_EX:  e_q[0] <= ecap;
        SP_EY:  e_q[1] <= ecap;
        SP_EZ:  e_q[2] <= ecap;
        SP_HX0: hv_q[0] <= prod[31:0];
        SP_HX1: hv_q[1] <= prod[31:0];
        SP_HY0: hv_q[2] <= prod[31:0];
        SP_HY1: hv_q[3] <= prod[31:0];
        SP_HZ0: hv_q[4] <= prod[31:0];
        SP_HZ1: hv_q[5] <= prod[31:0];
        SP_C0, SP_C1, SP_C2, SP_C3, SP_C4, SP_C5, SP_C6, SP_C7:
          n_q[cl] <= grad(hnib, gx, gy, gz);
        SP_LA0: a_q[0] <= bsum[19:0];
        SP_LA1: a_q[1] <= bsum[19:0];
        SP_LA2: a_q[2] <= bsum[19:0];
        SP_LA3: a_q[3] <= bsum[19:0];
        SP_LB0: b_q[0] <= bsum[19:0];
        SP_LB1: b_q[1] <= bsum[19:0];
        SP_LC:  nz_q   <= bsum[19:0];
        SP_FRQ: freq_q <= (|nf[27:24]) ? FREQ_MAX : nf[23:0];
        SP_AMP: amp_q  <= prod[32:16];
        SP_ACC: vsum_q <= vsum_q + $signed(prod[VSUM_W-1:0]);
        default: ;
      endcase
    end
  end

  fbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (vsum_q),
    .divisor_i  ({asum_q, 2'b00}),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  `FBM_ASSERT_IMP(a_done_idle, done_o, !busy, "result word shown while busy")
  `FBM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `FBM_ASSERT_NXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fractal 3D gradient noise block: directed points
// and random bursts are sent under several register settings, and every result
// word is compared with a noise value predicted inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

class noise_scoreboard;
  logic signed [15:0] pending_noise[$];
  int unsigned        mismatches;
  int unsigned        checked;

  function void note_point(logic signed [15:0] predicted);
    pending_noise.push_back(predicted);
  endfunction

  function void check_word(logic signed [15:0] actual);
    logic signed [15:0] want;
    if (pending_noise.size() == 0) begin
      $error("noise_value: unexpected word %0d", actual);
      mismatches++;
    end else begin
      want = pending_noise.pop_front();
      checked++;
      if (want !== actual) begin
        $error("noise_value: expected %0d actual %0d", want, actual);
        mismatches++;
      end
    end
  endfunction
endclass

module tb_top;
  import fbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int END_LATENCY    = 400;
  localparam int RAND_POINTS    = 950;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic               done_o;
  logic signed [15:0] noise_value_o;

  // bench copy of the registers
  logic [23:0] cfg_freq;
  logic [3:0]  cfg_octaves;
  logic [15:0] cfg_lacunarity;
  logic [15:0] cfg_persist;
  logic [31:0] cfg_seed;

  noise_scoreboard sb = new();
  int unsigned idle_cycles;
  int unsigned points_sent;

  always #5 clk_i = ~clk_i;

  fbm_perlin_noise_3d dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .done_o, .noise_value_o
  );

  always @(posedge clk_i) begin
    if (done_o) sb.check_word(noise_value_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] cz, logic [31:0] s);
    logic [31:0] h;
    h = s ^ (cx * HASH_CX) ^ (cy * HASH_CY) ^ (cz * HASH_CZ);
    h = h ^ (h >> 13);
    h = h * HASH_MIX;
    return h ^ (h >> 16);
  endfunction

  function automatic longint corner_dot(logic [3:0] h, longint gx, longint gy, longint gz);
    case (h)
      4'h0, 4'hc: return gx + gy;
      4'h1, 4'hd: return -gx + gy;
      4'h2, 4'he: return gx - gy;
      4'h3, 4'hf: return -gx - gy;
      4'h4:       return gx + gz;
      4'h5:       return -gx + gz;
      4'h6:       return gx - gz;
      4'h7:       return -gx - gz;
      4'h8:       return gy + gz;
      4'h9:       return -gy + gz;
      4'ha:       return gy - gz;
      default:    return -gy - gz;
    endcase
  endfunction

  // arithmetic shift right floors, as the blend needs
  function automatic longint lerp_q16(longint a, longint b, longint e);
    return a + (((b - a) * e) >>> 16);
  endfunction

  function automatic longint fade_q16(longint f);
    longint t2, t3, q, r;
    t2 = (f * f) >> 16;
    t3 = (t2 * f) >> 16;
    q  = 6 * t2 + 655360 - 15 * f;
    r  = (t3 * q) >> 16;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic longint octave_value(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz, logic [23:0] freq,
                                          logic [31:0] s);
    logic signed [63:0] prod[3];
    logic [31:0] lat[3], far[3];
    longint frac[3], fade[3], nf[3];
    longint n[8];
    longint a0, a1, a2, a3, b0, b1;
    prod[0] = 64'(px) * $signed({40'd0, freq});
    prod[1] = 64'(py) * $signed({40'd0, freq});
    prod[2] = 64'(pz) * $signed({40'd0, freq});
    for (int i = 0; i < 3; i++) begin
      lat[i]  = prod[i][63:32];
      far[i]  = lat[i] + 32'd1;
      frac[i] = longint'(prod[i][31:16]);
      nf[i]   = frac[i] - 65536;
      fade[i] = fade_q16(frac[i]);
    end
    for (int c = 0; c < 8; c++) begin
      n[c] = corner_dot(4'(lattice_hash(c[0] ? far[0] : lat[0], c[1] ? far[1] : lat[1],
                                        c[2] ? far[2] : lat[2], s)),
                        c[0] ? nf[0] : frac[0], c[1] ? nf[1] : frac[1],
                        c[2] ? nf[2] : frac[2]);
    end
    a0 = lerp_q16(n[0], n[1], fade[0]);
    a1 = lerp_q16(n[2], n[3], fade[0]);
    a2 = lerp_q16(n[4], n[5], fade[0]);
    a3 = lerp_q16(n[6], n[7], fade[0]);
    b0 = lerp_q16(a0, a1, fade[1]);
    b1 = lerp_q16(a2, a3, fade[1]);
    return lerp_q16(b0, b1, fade[2]);
  endfunction

  function automatic logic signed [15:0] fractal_noise(logic signed [31:0] px,
                                                       logic signed [31:0] py,
                                                       logic signed [31:0] pz);
    int unsigned count;
    longint freq, amp, vsum, asum, r, nxt;
    count = (cfg_octaves > MAX_OCTAVES) ? MAX_OCTAVES : cfg_octaves;
    freq = cfg_freq;
    amp = 65536;
    vsum = 0;
    asum = 0;
    r = 0;
    for (int unsigned k = 0; k < count; k++) begin
      vsum += amp * octave_value(px, py, pz, 24'(freq), cfg_seed + 32'(k) * SEED_STEP);
      asum += amp;
      nxt = (freq * cfg_lacunarity) >> 12;
      freq = (nxt > 64'hffffff) ? 64'hffffff : nxt;
      amp = (amp * cfg_persist) >> 16;
    end
    if (asum > 0) begin
      r = vsum / (asum * 4);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
    end
    return 16'(r);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BASE_FREQ: cfg_freq       = value[23:0];
      REG_OCT_COUNT: cfg_octaves    = value[3:0];
      REG_LACUNA:    cfg_lacunarity = value[15:0];
      REG_PERSIST:   cfg_persist    = value[15:0];
      REG_SEED:      cfg_seed       = value;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [23:0] f, logic [3:0] oc, logic [15:0] l,
                         logic [15:0] p, logic [31:0] s);
    write_reg(REG_BASE_FREQ, 32'(f));
    write_reg(REG_OCT_COUNT, 32'(oc));
    write_reg(REG_LACUNA, 32'(l));
    write_reg(REG_PERSIST, 32'(p));
    write_reg(REG_SEED, s);
  endtask

  // start is left high after acceptance so a following point can go straight
  // in; it is dropped before every gap
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
    start <= 1'b1;
    point_x <= px; point_y <= py; point_z <= pz;
    do @(posedge clk_i); while (busy);
    sb.note_point(fractal_noise(px, py, pz));
    points_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_noise.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000 + $urandom_range(0, 3);
      1:       return 32'sh7fff_ffff - $urandom_range(0, 3);
      2:       return $signed(32'($urandom_range(0, 65535)) - 32'd32768);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic random_phase(int unsigned points);
    int unsigned burst;
    while (points > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && points > 0) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        burst--;
        points--;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    idle_cycles = 0;
    points_sent = 0;
    cfg_freq = RST_BASE_FREQ;
    cfg_octaves = RST_OCT_COUNT;
    cfg_lacunarity = RST_LACUNA;
    cfg_persist = RST_PERSIST;
    cfg_seed = RST_SEED;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first, extremes of the coordinates
    send_point(32'sh0, 32'sh0, 32'sh0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh0001_8000, -32'sh0002_4000, 32'sh0000_ffff);
    send_point(-32'sh1, 32'sh1, 32'sh5555_aaaa);
    drain();
    // zero octaves give zero
    set_all(24'h010000, 4'd0, 16'h2000, 16'h8000, 32'h0);
    send_point(32'sh1234_5678, -32'sh0abc_def0, 32'sh7fff_0000);
    drain();
    // count above the limit, frequency saturating, full persistence
    set_all(24'hffffff, 4'hf, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_8000);
    send_point(32'sh0003_c000, 32'sh0007_1234, -32'sh0001_0001);
    drain();
    // single octave at unit frequency: near full-scale corners
    set_all(24'h010000, 4'd1, 16'h0000, 16'h0000, 32'h0000_0000);
    send_point(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    send_point(32'sh0000_ffff, 32'sh0000_0001, 32'sh0000_7fff);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0);
    drain();

    random_phase(RAND_POINTS / 4);
    drain();
    set_all(24'($urandom()), 4'($urandom_range(0, 9)), 16'($urandom()),
            16'($urandom()), $urandom());
    random_phase(RAND_POINTS / 4);
    drain();
    set_all(24'($urandom_range(1, 24'h04_0000)), 4'($urandom_range(1, 3)),
            16'($urandom_range(4096, 12288)), 16'($urandom()), $urandom());
    random_phase(RAND_POINTS / 4);
    drain();
    set_all(RST_BASE_FREQ, 4'd8, 16'hffff, 16'h0000, 32'h0);
    random_phase(RAND_POINTS / 4);

    start <= 1'b0;
    while (sb.pending_noise.size() != 0) @(posedge clk_i);
    repeat (END_LATENCY) @(posedge clk_i);
    $display("Sent %0d points over several register settings, %0d words checked.",
             points_sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending_noise.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/fbm_pkg.sv
hdl/fbm_mul.sv
hdl/fbm_div.sv
hdl/fbm_perlin_noise_3d.sv
bench/tb_top.sv
